[rtl/core/throttled_drop_tail_tx_queue_macros.svh]
// Assertion macros shared by the queue checker.
`ifndef THROTTLED_DROP_TAIL_TX_QUEUE_MACROS_SVH
`define THROTTLED_DROP_TAIL_TX_QUEUE_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define TDTQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tdtq check failed");

// Next-cycle implication, live during reset too.
`define TDTQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("tdtq check failed");

`endif

[rtl/core/tdtq_pkg.sv]
// Shared types, constants and helpers of the throttled drop-tail transmit queue.
`default_nettype none
package tdtq_pkg;

    localparam int QUEUE_DEPTH = 256;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CAP_W       = 9;
    localparam int TAG_W       = 16;
    localparam int SVC_W       = 16;
    localparam int CTICK_W     = 16;
    localparam int FACTOR_W    = 8;
    localparam int BUSY_W      = 24;
    localparam int ENTRY_W     = TAG_W + SVC_W;
    localparam int QLEN_W      = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // Front-end command queue
    localparam int FQ_DEPTH = 2;
    localparam int FQ_PTR_W = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
    localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

    localparam logic [1:0] MODE_TICK    = 2'd0;
    localparam logic [1:0] MODE_ARRIVAL = 2'd1;
    localparam logic [1:0] MODE_NOTICE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_CAPACITY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONGESTION_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOWDOWN_FACTOR  = 2'd2;

    localparam logic [CAP_W-1:0]    CAP_RESET    = 9'd256;
    localparam logic [CTICK_W-1:0]  CTICK_RESET  = 16'd6;
    localparam logic [FACTOR_W-1:0] FACTOR_RESET = 8'd30;

    typedef struct packed {
        logic [CAP_W-1:0]    queue_capacity;
        logic [CTICK_W-1:0]  congestion_ticks;
        logic [FACTOR_W-1:0] slowdown_factor;
    } t_cfg;

    // Decoded item handed from front to back
    typedef struct packed {
        logic             is_tick;
        logic             is_arrival;
        logic             is_notice;
        logic [TAG_W-1:0] packet_tag;
        logic [SVC_W-1:0] service_ticks;
    } t_cmd;

    typedef struct packed {
        logic              accepted;
        logic              dropped;
        logic              sent_valid;
        logic [TAG_W-1:0]  sent_tag;
        logic              congested;
        logic [QLEN_W-1:0] queue_length;
    } t_result;

    typedef enum logic [0:0] {
        ST_EXEC,
        ST_SEND
    } t_back_state;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] last;
        last = PTR_W'(QUEUE_DEPTH - 1);
        return (p == last) ? '0 : p + 1'b1;
    endfunction

endpackage
`default_nettype wire

[rtl/core/tdtq_front.sv]
// Front end: accepts input items, decodes the mode and buffers them for the back end.
`default_nettype none
module tdtq_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic [1:0]    i_mode,
    input  wire logic [15:0]   i_packet_tag,
    input  wire logic [15:0]   i_service_ticks,
    output logic               o_cmd_valid,
    input  wire logic          i_cmd_ready,
    output tdtq_pkg::t_cmd     o_cmd
);
    import tdtq_pkg::*;

    t_cmd               r_buf [FQ_DEPTH];
    logic [FQ_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [FQ_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [FQ_CNT_W-1:0] r_count, n_count;
    logic               push, pop;
    t_cmd               in_cmd;

    function automatic logic [FQ_PTR_W-1:0] fq_next(input logic [FQ_PTR_W-1:0] p);
        return (p == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // classify
    always_comb begin
        in_cmd.is_tick       = (i_mode == MODE_TICK);
        in_cmd.is_arrival    = (i_mode == MODE_ARRIVAL);
        in_cmd.is_notice     = (i_mode == MODE_NOTICE);
        in_cmd.packet_tag    = i_packet_tag;
        in_cmd.service_ticks = i_service_ticks;
    end

    assign o_in_ready  = (r_count != FQ_CNT_W'(FQ_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_buf[r_rd_ptr];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_wr_ptr = push ? fq_next(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = pop ? fq_next(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr_ptr] <= in_cmd;
        end
    end

endmodule
`default_nettype wire

[rtl/core/tdtq_back.sv]
// Back end: queue state, packet store, server countdown and result register.
`default_nettype none
module tdtq_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire tdtq_pkg::t_cfg i_cfg,
    input  wire logic          i_cmd_valid,
    output logic               o_cmd_ready,
    input  wire tdtq_pkg::t_cmd i_cmd,
    output logic               o_res_valid,
    input  wire logic          i_res_ready,
    output tdtq_pkg::t_result  o_res
);
    import tdtq_pkg::*;

    localparam int CMP_W = (FILL_W > CAP_W) ? FILL_W : CAP_W;
    localparam logic [FILL_W-1:0] DEPTH_FILL = FILL_W'(QUEUE_DEPTH);

    logic [ENTRY_W-1:0] r_store [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] r_rd_data;
    logic [ENTRY_W-1:0] r_byp_data, n_byp_data;
    logic               r_use_byp, n_use_byp;

    t_back_state        r_state, n_state;
    logic [PTR_W-1:0]   r_head, n_head;
    logic [PTR_W-1:0]   r_tail, n_tail;
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic [BUSY_W-1:0]  r_busy, n_busy;
    logic               r_cong, n_cong;
    logic [CTICK_W-1:0] r_ccnt, n_ccnt;
    t_result            r_pend, n_pend;
    t_result            r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic               out_free, take;
    logic               mem_we, mem_re;
    logic               cong1, act3, full, arr_ok, send, bypass;
    logic [CTICK_W-1:0] ccnt1, ccnt2;
    logic [BUSY_W-1:0]  busy2;
    logic [FILL_W-1:0]  fill2, fill3;
    logic [ENTRY_W-1:0] send_data;
    logic [BUSY_W-1:0]  prod;

    assign out_free    = !r_out_valid || i_res_ready;
    assign o_cmd_ready = (r_state == ST_EXEC) && out_free;
    assign take        = i_cmd_valid && o_cmd_ready;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    // step evaluation for the item at the back-end input
    assign cong1  = r_cong || i_cmd.is_notice;
    assign ccnt1  = (i_cmd.is_notice && !r_cong) ? i_cfg.congestion_ticks : r_ccnt;
    assign busy2  = (i_cmd.is_tick && r_busy != '0) ? r_busy - 1'b1 : r_busy;
    assign ccnt2  = (i_cmd.is_tick && ccnt1 != '0) ? ccnt1 - 1'b1 : ccnt1;
    assign act3   = cong1 && (ccnt2 != '0);
    assign full   = (CMP_W'(r_fill) >= CMP_W'(i_cfg.queue_capacity)) || (r_fill == DEPTH_FILL);
    assign arr_ok = i_cmd.is_arrival && !full;
    assign fill2  = arr_ok ? r_fill + 1'b1 : r_fill;
    assign send   = (busy2 == '0) && (fill2 != '0);
    assign fill3  = send ? fill2 - 1'b1 : fill2;
    // queue was empty: the packet sent is the one arriving now
    assign bypass = (r_fill == '0);
    assign mem_we = take && arr_ok;
    assign mem_re = take && send && !bypass;

    // service time, slowed while congested
    assign send_data = r_use_byp ? r_byp_data : r_rd_data;
    assign prod = r_pend.congested
        ? ({{(BUSY_W - SVC_W){1'b0}}, send_data[ENTRY_W-1:TAG_W]}
           * {{(BUSY_W - FACTOR_W){1'b0}}, i_cfg.slowdown_factor})
        : {{(BUSY_W - SVC_W){1'b0}}, send_data[ENTRY_W-1:TAG_W]};

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_fill      = r_fill;
        n_busy      = r_busy;
        n_cong      = r_cong;
        n_ccnt      = r_ccnt;
        n_pend      = r_pend;
        n_byp_data  = r_byp_data;
        n_use_byp   = r_use_byp;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_res_ready;

        case (r_state)
            ST_EXEC: begin
                if (take) begin
                    n_ccnt = ccnt2;
                    n_cong = act3;
                    n_busy = busy2;
                    n_fill = fill3;
                    if (arr_ok) begin
                        n_tail = ptr_next(r_tail);
                    end
                    n_pend.accepted     = arr_ok;
                    n_pend.dropped      = i_cmd.is_arrival && full;
                    n_pend.sent_valid   = 1'b0;
                    n_pend.sent_tag     = '0;
                    n_pend.congested    = act3;
                    n_pend.queue_length = QLEN_W'(fill3);
                    if (send) begin
                        n_head     = ptr_next(r_head);
                        n_use_byp  = bypass;
                        n_byp_data = {i_cmd.service_ticks, i_cmd.packet_tag};
                        n_state    = ST_SEND;
                    end else begin
                        n_out.accepted     = arr_ok;
                        n_out.dropped      = i_cmd.is_arrival && full;
                        n_out.sent_valid   = 1'b0;
                        n_out.sent_tag     = '0;
                        n_out.congested    = act3;
                        n_out.queue_length = QLEN_W'(fill3);
                        n_out_valid        = 1'b1;
                    end
                end
            end
            ST_SEND: begin
                if (out_free) begin
                    n_busy           = prod;
                    n_out            = r_pend;
                    n_out.sent_valid = 1'b1;
                    n_out.sent_tag   = send_data[TAG_W-1:0];
                    n_out_valid      = 1'b1;
                    n_state          = ST_EXEC;
                end
            end
            default: begin
                n_state = ST_EXEC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_EXEC;
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_busy      <= '0;
            r_cong      <= 1'b0;
            r_ccnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_fill      <= n_fill;
            r_busy      <= n_busy;
            r_cong      <= n_cong;
            r_ccnt      <= n_ccnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend     <= n_pend;
        r_out      <= n_out;
        r_byp_data <= n_byp_data;
        r_use_byp  <= n_use_byp;
    end

    // packet store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[r_tail] <= {i_cmd.service_ticks, i_cmd.packet_tag};
        end
        if (mem_re) begin
            r_rd_data <= r_store[r_head];
        end
    end

endmodule
`default_nettype wire

[rtl/core/throttled_drop_tail_tx_queue.sv]
// Top level of the throttled drop-tail transmit queue.
// Each input item is a tick, a packet arrival (tag, service ticks) or a congestion
// notice, and yields exactly one result item: accepted/dropped flags for an arrival,
// the tag of a packet sent this step (zero if none), the congestion flag and the
// queue length. A two-item front queue takes input items independently of the back
// end, which executes them one at a time. An item that sends no packet ends in the
// execute state; one that sends also passes the send state, where the packet store's
// registered read feeds the duration multiply that reloads the server countdown. The
// back end takes one item per cycle on steps without a send while the result register
// is free, and none in the send state. The packet store needs no clearing after reset:
// entries are only read after the arrival that wrote them. Configuration registers are
// written through i_cfg_we/i_cfg_idx/i_cfg_data and must only change while idle.
`default_nettype none
module throttled_drop_tail_tx_queue (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input items
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_mode,
    input  wire logic [15:0] i_packet_tag,
    input  wire logic [15:0] i_service_ticks,
    // result items
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_accepted,
    output logic             o_dropped,
    output logic             o_sent_valid,
    output logic [15:0]      o_sent_tag,
    output logic             o_congested,
    output logic [8:0]       o_queue_length,
    // configuration writes
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);
    import tdtq_pkg::*;

    t_cfg    r_cfg, n_cfg;
    t_cmd    cmd;
    logic    cmd_valid, cmd_ready;
    t_result res;

    // configuration registers; an unknown index is ignored
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_QUEUE_CAPACITY:   n_cfg.queue_capacity   = i_cfg_data[CAP_W-1:0];
                CFG_CONGESTION_TICKS: n_cfg.congestion_ticks = i_cfg_data[CTICK_W-1:0];
                CFG_SLOWDOWN_FACTOR:  n_cfg.slowdown_factor  = i_cfg_data[FACTOR_W-1:0];
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.queue_capacity   <= CAP_RESET;
            r_cfg.congestion_ticks <= CTICK_RESET;
            r_cfg.slowdown_factor  <= FACTOR_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // front: accept and decode
    tdtq_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_packet_tag    (i_packet_tag),
        .i_service_ticks (i_service_ticks),
        .o_cmd_valid     (cmd_valid),
        .i_cmd_ready     (cmd_ready),
        .o_cmd           (cmd)
    );

    // back: queue, server and result register
    tdtq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_res_valid (o_out_valid),
        .i_res_ready (i_out_ready),
        .o_res       (res)
    );

    assign o_accepted     = res.accepted;
    assign o_dropped      = res.dropped;
    assign o_sent_valid   = res.sent_valid;
    assign o_sent_tag     = res.sent_tag;
    assign o_congested    = res.congested;
    assign o_queue_length = res.queue_length;

endmodule
`default_nettype wire

[rtl/core/tdtq_checker.sv]
// Port-level checker for the transmit queue, bound to the top level.
`default_nettype none
`include "throttled_drop_tail_tx_queue_macros.svh"
module tdtq_port_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic        o_accepted,
    input wire logic        o_dropped,
    input wire logic        o_sent_valid,
    input wire logic [15:0] o_sent_tag,
    input wire logic [8:0]  o_queue_length
);
    // a result waiting on the sink holds
    `TDTQ_ASSERT_NEXT(a_out_hold, i_rst_n && o_out_valid && !i_out_ready, o_out_valid && $stable(o_sent_tag))
    // reset empties the result register
    `TDTQ_ASSERT_NEXT(a_rst_clear, !i_rst_n, !o_out_valid)
    // an arrival is either queued or dropped, never both
    `TDTQ_ASSERT_NOW(a_acc_drop, o_out_valid, !(o_accepted && o_dropped))
    // no send means a zero tag
    `TDTQ_ASSERT_NOW(a_tag_zero, o_out_valid && !o_sent_valid, o_sent_tag == 16'd0)
    // a queued arrival that was not sent leaves the queue non-empty
    `TDTQ_ASSERT_NOW(a_acc_len, o_out_valid && o_accepted && !o_sent_valid, o_queue_length != 9'd0)
endmodule

bind throttled_drop_tail_tx_queue tdtq_port_checker u_tdtq_checker (.*);
`default_nettype wire
